// ===== design/assert_macros.svh =====
// Concurrent check helpers for the leaf allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define LGFL_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is high
`define LGFL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== design/lgfl_pkg.sv =====
package lgfl_pkg;

   // Default geometry of the leaf pool
   localparam int MAX_GROUPS_DEF       = 16;
   localparam int LEAVES_PER_GROUP_DEF = 16;
   localparam int LEAF_BYTES_DEF       = 256;
   localparam int HEADER_BYTES_DEF     = 24;

   // Fixed-point scale of the reciprocal used to split an offset into slots
   localparam int RECIP_SHIFT = 27;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      RSP_OK       = 2'd0,
      RSP_NO_LEAF  = 2'd1,
      RSP_BAD_LEAF = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN,
      S_LAUNCH,
      S_DECODE,
      S_COMMIT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;
      logic open_push;
      logic dec_go;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_valid;
      logic in_free;
      logic stack_empty;
      logic group_left;
      logic open_last;
      logic dec_done;
      logic rsp_busy;
   } dp_status_type;

endpackage

// ===== design/lgfl_req_if.sv =====
interface lgfl_req_if;
   logic              valid;
   logic              ready;
   lgfl_pkg::cmd_type cmd;
   logic [7:0]        group_id;
   logic [15:0]       byte_offset;
   logic [7:0]        next_group;
   logic [15:0]       next_offset;

   modport source (
      output valid, cmd, group_id, byte_offset, next_group, next_offset,
      input  ready
   );

   modport sink (
      input  valid, cmd, group_id, byte_offset, next_group, next_offset,
      output ready
   );
endinterface

// ===== design/lgfl_rsp_if.sv =====
interface lgfl_rsp_if;
   logic                 valid;
   logic                 ready;
   lgfl_pkg::status_type status;
   logic [7:0]           leaf_group;
   logic [15:0]          leaf_offset;
   logic [4:0]           group_used;
   logic [8:0]           free_total;
   logic [7:0]           first_group;
   logic [15:0]          first_offset;

   modport source (
      output valid, status, leaf_group, leaf_offset, group_used, free_total,
             first_group, first_offset,
      input  ready
   );

   modport sink (
      input  valid, status, leaf_group, leaf_offset, group_used, free_total,
             first_group, first_offset,
      output ready
   );
endinterface

// ===== design/leaf_group_free_list_allocator_unit.sv =====
// Fixed-size leaf allocator with a LIFO free stack.
// req_ch carries one transaction per request: cmd selects allocate or free;
// a free names the leaf by group and byte offset and supplies the leaf's
// next pointer, which becomes the start leaf if the freed leaf was the start.
// rsp_ch returns one transaction per request: status, the leaf, its group's
// used count, the free-stack level and the current start leaf.
// Flow: a request is taken in the idle state, passes the launch step and the
// three-stage leaf decoder, and its result is loaded at the commit step; the
// next request is taken once the sequencer is idle again, one at a time.
// An allocation that finds the stack empty first opens the next group,
// pushing one slot per cycle. An allocation with no group left goes straight
// to commit and fails without a decode.
// Reset empties the stack, sets the next group to 1 and clears the start
// leaf; the used map of a group is cleared while the group is opened, so no
// clearing pass follows reset.
// A result waits in an output register; the next request is still accepted
// while it waits, and that request holds at its commit step until the
// waiting result has been taken.
`include "assert_macros.svh"

module leaf_group_free_list_allocator_unit #(
   parameter int MAX_GROUPS       = lgfl_pkg::MAX_GROUPS_DEF,
   parameter int LEAVES_PER_GROUP = lgfl_pkg::LEAVES_PER_GROUP_DEF,
   parameter int LEAF_BYTES       = lgfl_pkg::LEAF_BYTES_DEF,
   parameter int HEADER_BYTES     = lgfl_pkg::HEADER_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   lgfl_req_if.sink   req_ch,
   lgfl_rsp_if.source rsp_ch
);

   lgfl_pkg::ctrl_cmd_type  ctl_cmd;
   lgfl_pkg::dp_status_type dp_stat;

   lgfl_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .dp_stat (dp_stat),
      .ctl_cmd (ctl_cmd)
   );

   lgfl_dpath #(
      .MAX_GROUPS       (MAX_GROUPS),
      .LEAVES_PER_GROUP (LEAVES_PER_GROUP),
      .LEAF_BYTES       (LEAF_BYTES),
      .HEADER_BYTES     (HEADER_BYTES)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .ctl_cmd (ctl_cmd),
      .dp_stat (dp_stat)
   );

   // One transaction in flight: an accept closes the input for the next cycle
   `LGFL_ASSERT_NEXT(a_accept_closes, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // A commit always lands in the result register
   `LGFL_ASSERT_NEXT(a_commit_loads, clock, reset, ctl_cmd.commit, rsp_ch.valid)
   // Decoder results arrive only while a transaction is being worked on
   `LGFL_ASSERT_IMPL(a_done_busy, clock, reset, dp_stat.dec_done, !ctl_cmd.ready)
   // Never open a group beyond the last one
   `LGFL_ASSERT_IMPL(a_open_in_range, clock, reset, ctl_cmd.open_push, dp_stat.group_left)

endmodule

// ===== design/lgfl_decode.sv =====
// Three-stage leaf address decoder: (group, byte offset) to (group index, slot)
module lgfl_decode #(
   parameter int MAX_GROUPS       = lgfl_pkg::MAX_GROUPS_DEF,
   parameter int LEAVES_PER_GROUP = lgfl_pkg::LEAVES_PER_GROUP_DEF,
   parameter int LEAF_BYTES       = lgfl_pkg::LEAF_BYTES_DEF,
   parameter int HEADER_BYTES     = lgfl_pkg::HEADER_BYTES_DEF,
   localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
   localparam int SW  = (LEAVES_PER_GROUP > 1) ? $clog2(LEAVES_PER_GROUP) : 1,
   localparam int NGW = $clog2(MAX_GROUPS + 2)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [7:0]     group_id,
   input  logic [15:0]    byte_offset,
   input  logic [NGW-1:0] next_group,
   output logic           done,
   output logic           leaf_ok,
   output logic [GW-1:0]  leaf_grp,
   output logic [SW-1:0]  leaf_slot
);

   localparam int SPAN  = LEAVES_PER_GROUP * LEAF_BYTES;
   localparam int RECIP = (1 << lgfl_pkg::RECIP_SHIFT) / LEAF_BYTES + 1;
   localparam int RW    = $clog2(RECIP + 1);
   localparam int PW    = 16 + RW;

   logic [16:0]   rel_full;
   logic          in_span;
   logic          grp_ok;

   logic          s1_valid_ff;
   logic          s1_ok_ff;
   logic [15:0]   s1_rel_ff;
   logic [PW-1:0] s1_prod_ff;
   logic [GW-1:0] s1_grp_ff;

   logic          s2_valid_ff;
   logic          s2_ok_ff;
   logic [15:0]   s2_rel_ff;
   logic [15:0]   s2_slot_ff;
   logic [GW-1:0] s2_grp_ff;

   logic [31:0]   slot_back;

   logic          s3_valid_ff;
   logic          s3_ok_ff;
   logic [GW-1:0] s3_grp_ff;
   logic [SW-1:0] s3_slot_ff;

   // Offset below the header wraps high and so fails the span check too
   assign rel_full = {1'b0, byte_offset} - 17'(HEADER_BYTES);
   assign in_span  = rel_full < 17'(SPAN);
   assign grp_ok   = (group_id != 8'd0) &&
                     ({1'b0, group_id} < 9'(next_group)) &&
                     ({1'b0, group_id} <= 9'(MAX_GROUPS));

   // Stage 1: range checks and reciprocal product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= go;
      end
      s1_ok_ff   <= in_span && grp_ok;
      s1_rel_ff  <= rel_full[15:0];
      s1_prod_ff <= PW'(rel_full[15:0]) * PW'(RECIP);
      s1_grp_ff  <= GW'(group_id - 8'd1);
   end

   // Stage 2: slot quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ok_ff   <= s1_ok_ff;
      s2_rel_ff  <= s1_rel_ff;
      s2_slot_ff <= 16'(s1_prod_ff >> lgfl_pkg::RECIP_SHIFT);
      s2_grp_ff  <= s1_grp_ff;
   end

   // Stage 3: alignment check against the slot boundary
   assign slot_back = 32'(s2_slot_ff) * 32'(LEAF_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_ok_ff   <= s2_ok_ff && (slot_back == 32'(s2_rel_ff));
      s3_grp_ff  <= s2_grp_ff;
      s3_slot_ff <= SW'(s2_slot_ff);
   end

   assign done      = s3_valid_ff;
   assign leaf_ok   = s3_ok_ff;
   assign leaf_grp  = s3_grp_ff;
   assign leaf_slot = s3_slot_ff;

endmodule

// ===== design/lgfl_ctrl.sv =====
// Sequencer: accept, open a group if needed, decode, commit
module lgfl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  lgfl_pkg::dp_status_type dp_stat,
   output lgfl_pkg::ctrl_cmd_type  ctl_cmd
);

   lgfl_pkg::ctrl_state_type state_ff;
   lgfl_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgfl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         lgfl_pkg::S_IDLE: begin
            ctl_cmd.ready = 1'b1;
            if (dp_stat.in_valid) begin
               // Route on the incoming command and the stack level
               priority if (dp_stat.in_free) begin
                  state_in = lgfl_pkg::S_LAUNCH;
               end else if (!dp_stat.stack_empty) begin
                  state_in = lgfl_pkg::S_LAUNCH;
               end else if (dp_stat.group_left) begin
                  state_in = lgfl_pkg::S_OPEN;
               end else begin
                  state_in = lgfl_pkg::S_COMMIT;
               end
            end
         end
         lgfl_pkg::S_OPEN: begin
            ctl_cmd.open_push = 1'b1;
            if (dp_stat.open_last) begin
               state_in = lgfl_pkg::S_LAUNCH;
            end
         end
         lgfl_pkg::S_LAUNCH: begin
            ctl_cmd.dec_go = 1'b1;
            state_in       = lgfl_pkg::S_DECODE;
         end
         lgfl_pkg::S_DECODE: begin
            if (dp_stat.dec_done) begin
               state_in = lgfl_pkg::S_COMMIT;
            end
         end
         lgfl_pkg::S_COMMIT: begin
            // Hold until the result register can take the transaction
            if (!dp_stat.rsp_busy) begin
               ctl_cmd.commit = 1'b1;
               state_in       = lgfl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lgfl_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/lgfl_dpath.sv =====
// Allocator datapath: free stack, used map, per-group counts, start pointer
module lgfl_dpath #(
   parameter int MAX_GROUPS       = lgfl_pkg::MAX_GROUPS_DEF,
   parameter int LEAVES_PER_GROUP = lgfl_pkg::LEAVES_PER_GROUP_DEF,
   parameter int LEAF_BYTES       = lgfl_pkg::LEAF_BYTES_DEF,
   parameter int HEADER_BYTES     = lgfl_pkg::HEADER_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   lgfl_req_if.sink                req,
   lgfl_rsp_if.source              rsp,
   input  lgfl_pkg::ctrl_cmd_type  ctl_cmd,
   output lgfl_pkg::dp_status_type dp_stat
);

   localparam int TOTAL     = MAX_GROUPS * LEAVES_PER_GROUP;
   localparam int GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int SW        = (LEAVES_PER_GROUP > 1) ? $clog2(LEAVES_PER_GROUP) : 1;
   localparam int EW        = GW + SW;
   localparam int AW        = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int CW        = $clog2(TOTAL + 1);
   localparam int NGW       = $clog2(MAX_GROUPS + 2);
   localparam int UW        = $clog2(LEAVES_PER_GROUP + 1);
   localparam int MAP_DEPTH = 1 << EW;

   // Captured request
   lgfl_pkg::cmd_type op_cmd_ff;
   logic [7:0]        op_grp_ff;
   logic [15:0]       op_off_ff;
   logic [7:0]        op_ngrp_ff;
   logic [15:0]       op_noff_ff;

   // Control state
   logic [CW-1:0]     free_count_ff, free_count_in;
   logic [NGW-1:0]    next_group_ff, next_group_in;
   logic [SW-1:0]     open_slot_ff, open_slot_in;
   logic [7:0]        start_grp_ff, start_grp_in;
   logic [15:0]       start_off_ff, start_off_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Memories and their read registers
   logic [EW-1:0]     stack_mem [TOTAL];
   logic              used_mem  [MAP_DEPTH];
   logic [UW-1:0]     upg_mem   [MAX_GROUPS];
   logic [EW-1:0]     stk_top_ff;
   logic              used_a_ff;
   logic              used_b_ff;
   logic [UW-1:0]     upg_rd_ff;

   // Result register
   lgfl_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_grp_ff, rsp_grp_in;
   logic [15:0]       rsp_off_ff, rsp_off_in;
   logic [4:0]        rsp_used_ff, rsp_used_in;
   logic [8:0]        rsp_total_ff;

   // Decoder hookup
   logic [7:0]        dec_grp_sel;
   logic [15:0]       dec_off_sel;
   logic              dec_done;
   logic              dec_ok;
   logic [GW-1:0]     dec_g0;
   logic [SW-1:0]     dec_slot;
   logic [EW-1:0]     dec_entry;

   logic              accept;
   logic              is_free;
   logic [CW-1:0]     fc_m1;
   logic [GW-1:0]     top_g0;
   logic [SW-1:0]     top_slot;
   logic [GW-1:0]     open_g0;
   logic [EW-1:0]     open_entry;
   logic              open_last;
   logic [GW-1:0]     upg_addr;
   logic              alloc_ok;
   logic              start_live;
   logic              free_ok;
   logic              stack_room;
   logic              is_start;
   logic              commit_alloc;
   logic              commit_free;
   logic [7:0]        a_grp;
   logic [15:0]       a_off;
   logic [UW-1:0]     a_used_new;
   logic [UW-1:0]     f_used_new;

   assign accept    = req.valid && req.ready;
   assign req.ready = ctl_cmd.ready;
   assign is_free   = (op_cmd_ff == lgfl_pkg::CMD_FREE);

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         op_cmd_ff  <= req.cmd;
         op_grp_ff  <= req.group_id;
         op_off_ff  <= req.byte_offset;
         op_ngrp_ff <= req.next_group;
         op_noff_ff <= req.next_offset;
      end
   end

   // Decode the freed leaf, or the start leaf for an allocation
   assign dec_grp_sel = is_free ? op_grp_ff : start_grp_ff;
   assign dec_off_sel = is_free ? op_off_ff : start_off_ff;

   lgfl_decode #(
      .MAX_GROUPS       (MAX_GROUPS),
      .LEAVES_PER_GROUP (LEAVES_PER_GROUP),
      .LEAF_BYTES       (LEAF_BYTES),
      .HEADER_BYTES     (HEADER_BYTES)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .go          (ctl_cmd.dec_go),
      .group_id    (dec_grp_sel),
      .byte_offset (dec_off_sel),
      .next_group  (next_group_ff),
      .done        (dec_done),
      .leaf_ok     (dec_ok),
      .leaf_grp    (dec_g0),
      .leaf_slot   (dec_slot)
   );

   assign dec_entry  = {dec_g0, dec_slot};
   assign fc_m1      = free_count_ff - CW'(1);
   assign top_g0     = stk_top_ff[EW-1:SW];
   assign top_slot   = stk_top_ff[SW-1:0];
   assign open_g0    = GW'(next_group_ff - NGW'(1));
   assign open_entry = {open_g0, open_slot_ff};
   assign open_last  = (open_slot_ff == SW'(LEAVES_PER_GROUP - 1));
   assign upg_addr   = is_free ? dec_g0 : top_g0;

   // Read ports, registered every cycle
   always_ff @(posedge clock) begin
      stk_top_ff <= stack_mem[fc_m1[AW-1:0]];
      used_a_ff  <= used_mem[dec_entry];
      used_b_ff  <= used_mem[stk_top_ff];
      upg_rd_ff  <= upg_mem[upg_addr];
   end

   // Commit terms
   assign alloc_ok     = (free_count_ff != '0);
   assign start_live   = dec_ok && used_a_ff;
   assign free_ok      = dec_ok && used_a_ff;
   assign stack_room   = (free_count_ff < CW'(TOTAL));
   assign is_start     = (start_grp_ff == op_grp_ff) && (start_off_ff == op_off_ff);
   assign commit_alloc = ctl_cmd.commit && !is_free && alloc_ok;
   assign commit_free  = ctl_cmd.commit && is_free && free_ok;
   assign a_grp        = 8'(top_g0) + 8'd1;
   assign a_off        = 16'(32'(HEADER_BYTES) + 32'(top_slot) * 32'(LEAF_BYTES));
   assign a_used_new   = used_b_ff ? upg_rd_ff : upg_rd_ff + UW'(1);
   assign f_used_new   = (upg_rd_ff != '0) ? upg_rd_ff - UW'(1) : '0;

   // Memory writes: group opening clears and pushes, an allocation marks, a free clears and pushes
   always_ff @(posedge clock) begin
      if (ctl_cmd.open_push) begin
         stack_mem[free_count_ff[AW-1:0]] <= open_entry;
         used_mem[open_entry]             <= 1'b0;
         upg_mem[open_g0]                 <= '0;
      end else if (commit_alloc) begin
         used_mem[stk_top_ff] <= 1'b1;
         upg_mem[top_g0]      <= a_used_new;
      end else if (commit_free) begin
         if (stack_room) begin
            stack_mem[free_count_ff[AW-1:0]] <= dec_entry;
         end
         used_mem[dec_entry] <= 1'b0;
         upg_mem[dec_g0]     <= f_used_new;
      end
   end

   // Next values of the control state
   always_comb begin
      free_count_in = free_count_ff;
      next_group_in = next_group_ff;
      open_slot_in  = open_slot_ff;
      start_grp_in  = start_grp_ff;
      start_off_in  = start_off_ff;
      if (ctl_cmd.open_push) begin
         free_count_in = free_count_ff + CW'(1);
         open_slot_in  = open_last ? '0 : open_slot_ff + SW'(1);
         if (open_last) begin
            next_group_in = next_group_ff + NGW'(1);
         end
      end
      if (commit_alloc) begin
         free_count_in = free_count_ff - CW'(1);
         if (!start_live) begin
            start_grp_in = a_grp;
            start_off_in = a_off;
         end
      end
      if (commit_free) begin
         if (stack_room) begin
            free_count_in = free_count_ff + CW'(1);
         end
         if (is_start) begin
            start_grp_in = op_ngrp_ff;
            start_off_in = op_noff_ff;
         end
      end
   end

   // Result fields and handshake
   always_comb begin
      rsp_status_in = lgfl_pkg::RSP_OK;
      rsp_grp_in    = '0;
      rsp_off_in    = '0;
      rsp_used_in   = '0;
      if (is_free) begin
         if (free_ok) begin
            rsp_grp_in  = op_grp_ff;
            rsp_off_in  = op_off_ff;
            rsp_used_in = 5'(f_used_new);
         end else begin
            rsp_status_in = lgfl_pkg::RSP_BAD_LEAF;
         end
      end else begin
         if (alloc_ok) begin
            rsp_grp_in  = a_grp;
            rsp_off_in  = a_off;
            rsp_used_in = 5'(a_used_new);
         end else begin
            rsp_status_in = lgfl_pkg::RSP_NO_LEAF;
         end
      end
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (ctl_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         next_group_ff <= NGW'(1);
         open_slot_ff  <= '0;
         start_grp_ff  <= '0;
         start_off_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         next_group_ff <= next_group_in;
         open_slot_ff  <= open_slot_in;
         start_grp_ff  <= start_grp_in;
         start_off_ff  <= start_off_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Load the result register at commit; state fields carry post-operation values
   always_ff @(posedge clock) begin
      if (ctl_cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_grp_ff    <= rsp_grp_in;
         rsp_off_ff    <= rsp_off_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_total_ff  <= 9'(free_count_in);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.leaf_group   = rsp_grp_ff;
   assign rsp.leaf_offset  = rsp_off_ff;
   assign rsp.group_used   = rsp_used_ff;
   assign rsp.free_total   = rsp_total_ff;
   assign rsp.first_group  = start_grp_ff;
   assign rsp.first_offset = start_off_ff;

   // Status towards the sequencer
   assign dp_stat.in_valid    = req.valid;
   assign dp_stat.in_free     = (req.cmd == lgfl_pkg::CMD_FREE);
   assign dp_stat.stack_empty = (free_count_ff == '0);
   assign dp_stat.group_left  = (next_group_ff <= NGW'(MAX_GROUPS));
   assign dp_stat.open_last   = open_last;
   assign dp_stat.dec_done    = dec_done;
   assign dp_stat.rsp_busy    = rsp_valid_ff && !rsp.ready;

endmodule
